// ----- rtl/hcsg_pkg.sv -----
// shared types, constants and the level-step microcode table of the hilbert segment generator
`default_nettype none

package hcsg_pkg;

    localparam int unsigned MAX_ORDER   = 8;
    localparam int unsigned STACK_DEPTH = MAX_ORDER;
    localparam int unsigned ORD_W       = 4;
    localparam int unsigned COORD_W     = 9;
    localparam int unsigned PC_W        = 3;
    localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
    localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SEG_W       = 2 * MAX_ORDER;

    localparam logic [COORD_W-1:0] BASE_LEN = COORD_W'(479);

    typedef logic [PC_W-1:0] t_pc;

    // one control word per level step
    typedef struct packed {
        logic rot;       // turn left or right
        logic rot_inv;   // turn against the level parity
        logic push;      // descend one level if not at the bottom
        logic push_inv;  // child gets the opposite parity
        logic fwd;       // draw one segment
        logic pop;       // level finished
    } t_uop;

    typedef struct packed {
        logic init;
        logic step;
        logic push;
        logic push_neg;
        logic pop;
    } t_stk_ctl;

    typedef struct packed {
        logic init;
        logic rot;
        logic rot_neg;
        logic fwd;
    } t_trt_ctl;

    function automatic t_uop uop_rom(input t_pc pc);
        t_uop w;
        w = '0;
        unique case (pc)
            3'd0: begin w.rot = 1'b1; w.push = 1'b1; w.push_inv = 1'b1; end
            3'd1: begin w.fwd = 1'b1; end
            3'd2: begin w.rot = 1'b1; w.rot_inv = 1'b1; w.push = 1'b1; end
            3'd3: begin w.fwd = 1'b1; end
            3'd4: begin w.push = 1'b1; end
            3'd5: begin w.rot = 1'b1; w.rot_inv = 1'b1; w.fwd = 1'b1; end
            3'd6: begin w.push = 1'b1; w.push_inv = 1'b1; end
            3'd7: begin w.rot = 1'b1; w.pop = 1'b1; end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hcsg_level_stack.sv -----
// level stack: per-level step counter and parity, with push, pop and step update
`default_nettype none

module hcsg_level_stack (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire hcsg_pkg::t_stk_ctl          i_ctl,
    output hcsg_pkg::t_pc                    o_top_pc,
    output logic                             o_top_neg,
    output logic [hcsg_pkg::DEPTH_W-1:0]     o_depth
);

    // entry is {parity, step counter}
    logic [hcsg_pkg::PC_W:0]         r_stack [hcsg_pkg::STACK_DEPTH];
    logic [hcsg_pkg::DEPTH_W-1:0]    r_depth;
    logic [hcsg_pkg::DEPTH_W-1:0]    w_top;
    logic [hcsg_pkg::IDX_W-1:0]      w_top_idx;
    logic [hcsg_pkg::IDX_W-1:0]      w_push_idx;
    logic                            w_room;
    logic [hcsg_pkg::PC_W:0]         w_top_entry;

    assign w_top       = r_depth - 1'b1;
    assign w_top_idx   = w_top[hcsg_pkg::IDX_W-1:0];
    assign w_push_idx  = r_depth[hcsg_pkg::IDX_W-1:0];
    assign w_room      = r_depth < hcsg_pkg::DEPTH_W'(hcsg_pkg::STACK_DEPTH);
    assign w_top_entry = r_stack[w_top_idx];

    assign o_top_pc  = w_top_entry[hcsg_pkg::PC_W-1:0];
    assign o_top_neg = w_top_entry[hcsg_pkg::PC_W];
    assign o_depth   = r_depth;

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            if (i_ctl.push) begin
                r_stack[0] <= '0;
            end
        end else begin
            if (i_ctl.step) begin
                r_stack[w_top_idx] <= {o_top_neg, o_top_pc + 1'b1};
            end
            if (i_ctl.push && w_room) begin
                r_stack[w_push_idx] <= {i_ctl.push_neg, hcsg_pkg::PC_W'(0)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_ctl.init) begin
            r_depth <= i_ctl.push ? hcsg_pkg::DEPTH_W'(1) : '0;
        end else if (i_ctl.pop) begin
            r_depth <= r_depth - 1'b1;
        end else if (i_ctl.push && w_room) begin
            r_depth <= r_depth + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcsg_turtle.sv -----
// turtle: heading and pen position, turning and forward moves
`default_nettype none

module hcsg_turtle (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire hcsg_pkg::t_trt_ctl          i_ctl,
    input  wire  [hcsg_pkg::COORD_W-1:0]     i_step,
    output logic [hcsg_pkg::COORD_W-1:0]     o_pos_x,
    output logic [hcsg_pkg::COORD_W-1:0]     o_pos_y,
    output logic [hcsg_pkg::COORD_W-1:0]     o_nxt_x,
    output logic [hcsg_pkg::COORD_W-1:0]     o_nxt_y
);

    localparam logic [1:0] HEAD_EAST  = 2'd0;
    localparam logic [1:0] HEAD_NORTH = 2'd1;
    localparam logic [1:0] HEAD_WEST  = 2'd2;
    localparam logic [1:0] HEAD_SOUTH = 2'd3;

    logic [1:0]                   r_head;
    logic [1:0]                   w_head;
    logic [hcsg_pkg::COORD_W-1:0] r_pos_x;
    logic [hcsg_pkg::COORD_W-1:0] r_pos_y;

    // a turn and a move in the same step move along the new heading
    assign w_head = i_ctl.rot ? (r_head + (i_ctl.rot_neg ? 2'd3 : 2'd1)) : r_head;

    always_comb begin
        o_nxt_x = r_pos_x;
        o_nxt_y = r_pos_y;
        unique case (w_head)
            HEAD_EAST:  o_nxt_x = r_pos_x + i_step;
            HEAD_NORTH: o_nxt_y = r_pos_y + i_step;
            HEAD_WEST:  o_nxt_x = r_pos_x - i_step;
            HEAD_SOUTH: o_nxt_y = r_pos_y - i_step;
            default:    o_nxt_x = r_pos_x;
        endcase
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= HEAD_EAST;
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_ctl.init) begin
            r_head  <= HEAD_EAST;
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else begin
            r_head <= w_head;
            if (i_ctl.fwd) begin
                r_pos_x <= o_nxt_x;
                r_pos_y <= o_nxt_y;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hilbert_curve_segment_generator.sv -----
// top level: microcoded level-stack sequencer that emits hilbert curve segments
// a word is accepted while idle, then the walk runs microcode steps of the level stack until one
//   draws a segment or none is left, the first segment of a curve included
// throughput: one word in flight; the next word is accepted once its result is registered
// the result waits in an output register, so the next word may be taken meanwhile
// reset: synchronous, active low; clears control state and sets curve_order to 1,
//   the level stack is not cleared since every entry is pushed before it is read
`default_nettype none

module hilbert_curve_segment_generator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [hcsg_pkg::ORD_W-1:0]       i_cfg_wdata,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_start_req,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [hcsg_pkg::COORD_W-1:0]     o_from_x,
    output logic [hcsg_pkg::COORD_W-1:0]     o_from_y,
    output logic [hcsg_pkg::COORD_W-1:0]     o_to_x,
    output logic [hcsg_pkg::COORD_W-1:0]     o_to_y,
    output logic                             o_last_segment,
    output logic                             o_done_res
);

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    t_state                         r_state;
    logic [hcsg_pkg::ORD_W-1:0]     r_order;
    logic [hcsg_pkg::ORD_W-1:0]     r_run_order;
    logic                           r_active;
    logic [hcsg_pkg::SEG_W-1:0]     r_seg_left;

    logic                           w_accept;
    logic                           w_start;
    logic [hcsg_pkg::ORD_W-1:0]     w_ord_sat;
    logic [hcsg_pkg::SEG_W:0]       w_seg_full;
    logic [hcsg_pkg::SEG_W-1:0]     w_seg_init;
    hcsg_pkg::t_pc                  w_top_pc;
    logic                           w_top_neg;
    logic [hcsg_pkg::DEPTH_W-1:0]   w_depth;
    hcsg_pkg::t_uop                 w_uop;
    logic                           w_walk;
    logic                           w_none;
    logic                           w_finish;
    logic                           w_out_free;
    logic                           w_go;
    logic                           w_exec;
    logic                           w_deeper;
    logic [hcsg_pkg::COORD_W-1:0]   w_step;
    logic [hcsg_pkg::COORD_W-1:0]   w_pos_x;
    logic [hcsg_pkg::COORD_W-1:0]   w_pos_y;
    logic [hcsg_pkg::COORD_W-1:0]   w_nxt_x;
    logic [hcsg_pkg::COORD_W-1:0]   w_nxt_y;
    hcsg_pkg::t_stk_ctl             w_stk_ctl;
    hcsg_pkg::t_trt_ctl             w_trt_ctl;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_start  = w_accept && i_start_req;

    assign w_ord_sat  = (r_order > hcsg_pkg::ORD_W'(hcsg_pkg::MAX_ORDER))
                      ? hcsg_pkg::ORD_W'(hcsg_pkg::MAX_ORDER) : r_order;
    assign w_seg_full = (hcsg_pkg::SEG_W+1)'(1) << {w_ord_sat, 1'b0};
    assign w_seg_init = hcsg_pkg::SEG_W'(w_seg_full - 1'b1);

    assign w_uop      = hcsg_pkg::uop_rom(w_top_pc);
    assign w_walk     = (r_state == ST_WALK);
    assign w_none     = !r_active || (r_seg_left == '0) || (w_depth == '0);
    assign w_finish   = w_walk && (w_none || w_uop.fwd);
    assign w_out_free = !o_valid || i_ready;
    // hold the whole step while a finished result cannot be registered
    assign w_go       = w_walk && !(w_finish && !w_out_free);
    assign w_exec     = w_go && !w_none;
    assign w_deeper   = w_depth < hcsg_pkg::DEPTH_W'(r_run_order);
    assign w_step     = hcsg_pkg::BASE_LEN >> r_run_order;

    always_comb begin
        w_stk_ctl          = '0;
        w_stk_ctl.init     = w_start;
        w_stk_ctl.step     = w_exec;
        w_stk_ctl.pop      = w_exec && w_uop.pop;
        w_stk_ctl.push     = w_start ? (w_ord_sat != '0) : (w_exec && w_uop.push && w_deeper);
        w_stk_ctl.push_neg = w_start ? 1'b0 : (w_top_neg ^ w_uop.push_inv);

        w_trt_ctl          = '0;
        w_trt_ctl.init     = w_start;
        w_trt_ctl.rot      = w_exec && w_uop.rot;
        w_trt_ctl.rot_neg  = w_top_neg ^ w_uop.rot_inv;
        w_trt_ctl.fwd      = w_exec && w_uop.fwd;
    end

    hcsg_level_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_stk_ctl),
        .o_top_pc  (w_top_pc),
        .o_top_neg (w_top_neg),
        .o_depth   (w_depth)
    );

    hcsg_turtle u_turtle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_trt_ctl),
        .i_step  (w_step),
        .o_pos_x (w_pos_x),
        .o_pos_y (w_pos_y),
        .o_nxt_x (w_nxt_x),
        .o_nxt_y (w_nxt_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_order        <= hcsg_pkg::ORD_W'(1);
            r_run_order    <= '0;
            r_active       <= 1'b0;
            r_seg_left     <= '0;
            o_valid        <= 1'b0;
            o_from_x       <= '0;
            o_from_y       <= '0;
            o_to_x         <= '0;
            o_to_y         <= '0;
            o_last_segment <= 1'b0;
            o_done_res     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end

            if (o_valid && i_ready && !(w_go && w_finish)) begin
                o_valid <= 1'b0;
            end

            if (w_accept) begin
                r_state <= ST_WALK;
                if (i_start_req) begin
                    r_run_order <= w_ord_sat;
                    r_active    <= (w_ord_sat != '0);
                    r_seg_left  <= w_seg_init;
                end
            end

            if (w_go && w_finish) begin
                r_state <= ST_IDLE;
                o_valid <= 1'b1;
                if (w_none) begin
                    r_active       <= 1'b0;
                    o_from_x       <= '0;
                    o_from_y       <= '0;
                    o_to_x         <= '0;
                    o_to_y         <= '0;
                    o_last_segment <= 1'b0;
                    o_done_res     <= 1'b1;
                end else begin
                    r_seg_left     <= r_seg_left - 1'b1;
                    o_from_x       <= w_pos_x;
                    o_from_y       <= w_pos_y;
                    o_to_x         <= w_nxt_x;
                    o_to_y         <= w_nxt_y;
                    o_last_segment <= (r_seg_left == hcsg_pkg::SEG_W'(1));
                    o_done_res     <= 1'b0;
                    if (r_seg_left == hcsg_pkg::SEG_W'(1)) begin
                        r_active <= 1'b0;
                    end
                end
            end
        end
    end

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_from_x == '0 && o_from_y == '0 && o_to_x == '0
                                  && o_to_y == '0 && !o_last_segment)
        else $error("done result carries nonzero fields");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_depth <= hcsg_pkg::DEPTH_W'(r_run_order))
        else $error("level stack deeper than the curve order");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec && w_uop.fwd && r_seg_left == hcsg_pkg::SEG_W'(1)
        |=> !r_active && r_state == ST_IDLE && o_valid && o_last_segment)
        else $error("final segment did not end the curve");

    a_no_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_walk |-> !w_stk_ctl.step && !w_trt_ctl.fwd && !w_trt_ctl.rot)
        else $error("microcode step issued outside the walk");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench of the hilbert curve segment generator
`default_nettype none

module tb_top;

    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 1300;

    typedef enum int {
        MODE_STEADY,
        MODE_TX_GAPS,
        MODE_RX_STALLS,
        MODE_BOTH
    } t_idle_mode;

    // steps of one level, in program counter order
    typedef enum logic [hcsg_pkg::PC_W-1:0] {
        STEP_TURN_IN,
        STEP_FWD_FIRST,
        STEP_TURN_OUT,
        STEP_FWD_SECOND,
        STEP_DESCEND_MID,
        STEP_TURN_FWD_THIRD,
        STEP_DESCEND_LAST,
        STEP_RETURN
    } t_level_step;

    typedef struct packed {
        logic [hcsg_pkg::COORD_W-1:0] from_x;
        logic [hcsg_pkg::COORD_W-1:0] from_y;
        logic [hcsg_pkg::COORD_W-1:0] to_x;
        logic [hcsg_pkg::COORD_W-1:0] to_y;
        logic                         last_segment;
        logic                         done_res;
    } t_seg;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [hcsg_pkg::ORD_W-1:0]   i_cfg_wdata = '0;
    logic                         i_valid     = 1'b0;
    logic                         i_start_req = 1'b0;
    logic                         i_ready     = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [hcsg_pkg::COORD_W-1:0] o_from_x;
    logic [hcsg_pkg::COORD_W-1:0] o_from_y;
    logic [hcsg_pkg::COORD_W-1:0] o_to_x;
    logic [hcsg_pkg::COORD_W-1:0] o_to_y;
    logic                         o_last_segment;
    logic                         o_done_res;

    hilbert_curve_segment_generator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_req    (i_start_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_from_x       (o_from_x),
        .o_from_y       (o_from_y),
        .o_to_x         (o_to_x),
        .o_to_y         (o_to_y),
        .o_last_segment (o_last_segment),
        .o_done_res     (o_done_res)
    );

    // turtle state mirrored from the block
    logic [hcsg_pkg::ORD_W-1:0]   m_order;
    logic [hcsg_pkg::ORD_W-1:0]   m_run_order;
    logic [1:0]                   m_heading;
    logic [hcsg_pkg::COORD_W-1:0] m_pos_x;
    logic [hcsg_pkg::COORD_W-1:0] m_pos_y;
    logic [3:0]                   m_stack [hcsg_pkg::STACK_DEPTH];
    logic [3:0]                   m_depth;
    int unsigned                  m_segs_left;
    logic                         m_active;

    logic       start_bits_q [$];
    t_seg       pending_segs [$];
    t_idle_mode idle_mode   = MODE_STEADY;
    logic       in_taken    = 1'b0;
    bit         rx_hold     = 1'b0;
    bit         pressure_go = 1'b0;
    int         errors      = 0;
    int         n_words     = 0;
    int         n_starts    = 0;
    int         n_results   = 0;
    int         n_done      = 0;
    int         n_last      = 0;
    logic [15:0] orders_written = '0;

    function void reset_turtle();
        m_order     = hcsg_pkg::ORD_W'(1);
        m_run_order = '0;
        m_heading   = '0;
        m_pos_x     = '0;
        m_pos_y     = '0;
        m_depth     = '0;
        m_segs_left = 0;
        m_active    = 1'b0;
        for (int i = 0; i < hcsg_pkg::STACK_DEPTH; i++) m_stack[i] = '0;
    endfunction

    function void turn(input logic neg);
        m_heading = m_heading + (neg ? 2'd3 : 2'd1);
    endfunction

    function void descend(input logic neg);
        if (m_depth < hcsg_pkg::STACK_DEPTH) begin
            m_stack[m_depth[2:0]] = {neg, 3'd0};
            m_depth = m_depth + 4'd1;
        end
    endfunction

    function void draw(inout t_seg r);
        logic [hcsg_pkg::COORD_W-1:0] len;
        logic [hcsg_pkg::COORD_W-1:0] nx;
        logic [hcsg_pkg::COORD_W-1:0] ny;
        len = hcsg_pkg::BASE_LEN >> m_run_order;
        nx  = m_pos_x;
        ny  = m_pos_y;
        case (m_heading)
            2'd0: nx = nx + len;
            2'd1: ny = ny + len;
            2'd2: nx = nx - len;
            default: ny = ny - len;
        endcase
        r.from_x = m_pos_x;
        r.from_y = m_pos_y;
        r.to_x   = nx;
        r.to_y   = ny;
        m_pos_x  = nx;
        m_pos_y  = ny;
    endfunction

    // run the level stack up to the next forward move
    function bit walk_levels(inout t_seg r);
        logic [2:0] idx;
        logic [3:0] fr;
        logic       neg;
        logic [2:0] pc;
        logic       deeper;
        bit         hit;
        hit = 1'b0;
        while (!hit && m_depth > 0 && m_depth <= hcsg_pkg::STACK_DEPTH) begin
            idx    = 3'(m_depth - 4'd1);
            fr     = m_stack[idx];
            neg    = fr[3];
            pc     = fr[2:0];
            deeper = (m_run_order - {1'b0, idx}) > 4'd1;
            m_stack[idx] = {fr[3], pc + 3'd1};
            case (pc)
                STEP_TURN_IN: begin
                    turn(neg);
                    if (deeper) descend(!neg);
                end
                STEP_FWD_FIRST, STEP_FWD_SECOND: begin
                    draw(r);
                    hit = 1'b1;
                end
                STEP_TURN_OUT: begin
                    turn(!neg);
                    if (deeper) descend(neg);
                end
                STEP_DESCEND_MID: begin
                    if (deeper) descend(neg);
                end
                STEP_TURN_FWD_THIRD: begin
                    turn(!neg);
                    draw(r);
                    hit = 1'b1;
                end
                STEP_DESCEND_LAST: begin
                    if (deeper) descend(!neg);
                end
                default: begin
                    turn(neg);
                    m_depth = m_depth - 4'd1;
                end
            endcase
        end
        return hit;
    endfunction

    function t_seg next_curve_segment(input logic start);
        t_seg                       r;
        logic [hcsg_pkg::ORD_W-1:0] ord;
        r = '0;
        if (start) begin
            ord = (m_order > hcsg_pkg::MAX_ORDER) ? hcsg_pkg::ORD_W'(hcsg_pkg::MAX_ORDER)
                                                  : m_order;
            m_heading   = '0;
            m_pos_x     = '0;
            m_pos_y     = '0;
            m_depth     = '0;
            m_run_order = ord;
            if (ord == 0) begin
                m_active    = 1'b0;
                m_segs_left = 0;
            end else begin
                m_active    = 1'b1;
                m_segs_left = (1 << (2 * ord)) - 1;
                descend(1'b0);
            end
        end
        if (!m_active || m_segs_left == 0 || !walk_levels(r)) begin
            r          = '0;
            r.done_res = 1'b1;
            m_active   = 1'b0;
        end else begin
            m_segs_left--;
            if (m_segs_left == 0) begin
                r.last_segment = 1'b1;
                m_active       = 1'b0;
            end
        end
        return r;
    endfunction

    function int tx_idle_pct();
        case (idle_mode)
            MODE_TX_GAPS: return 50;
            MODE_BOTH:    return 20;
            default:      return 0;
        endcase
    endfunction

    function int rx_stall_pct();
        case (idle_mode)
            MODE_RX_STALLS: return 50;
            MODE_BOTH:      return 20;
            default:        return 0;
        endcase
    endfunction

    function void queue_words(input bit with_start, input int advances);
        if (with_start) start_bits_q.push_back(1'b1);
        for (int i = 0; i < advances; i++) start_bits_q.push_back(1'b0);
    endfunction

    task automatic wait_drained();
        while (start_bits_q.size() != 0 || i_valid || pending_segs.size() != 0)
            @(negedge i_clk);
    endtask

    // the block may still be busy after the last result, so let it settle
    task automatic write_order(input logic [hcsg_pkg::ORD_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        m_order = v;
        orders_written[v] = 1'b1;
    endtask

    task automatic report_failure(input string msg);
        if (errors < 10) $display("%0t: %s", $realtime, msg);
        errors++;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (start_bits_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
                i_valid     <= 1'b1;
                i_start_req <= start_bits_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct());
        end
    end

    always @(posedge i_clk) begin : monitor
        t_seg got;
        t_seg want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;
            // pop before push: a word's result never leaves on its own accept edge
            if (o_valid && i_ready) begin
                got.from_x       = o_from_x;
                got.from_y       = o_from_y;
                got.to_x         = o_to_x;
                got.to_y         = o_to_y;
                got.last_segment = o_last_segment;
                got.done_res     = o_done_res;
                n_results++;
                if (o_done_res === 1'b1) n_done++;
                if (o_last_segment === 1'b1) n_last++;
                if (pending_segs.size() == 0) begin
                    report_failure($sformatf("unexpected result %p", got));
                end else begin
                    want = pending_segs.pop_front();
                    if (got !== want)
                        report_failure($sformatf("segment mismatch: exp %p got %p", want, got));
                end
            end
            if (i_valid && o_ready) begin
                n_words++;
                if (i_start_req) n_starts++;
                pending_segs.push_back(next_curve_segment(i_start_req));
            end
        end
    end

    initial begin
        int          random_words;
        int          phase;
        int          adv;
        logic [3:0]  ord;
        int          eff;
        reset_turtle();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: advance while idle, a full order-1 curve and advances past its end
        idle_mode = MODE_STEADY;
        queue_words(1'b0, 1);
        queue_words(1'b1, 3);
        // order zero gives no segments
        write_order(4'd0);
        queue_words(1'b1, 1);
        // order above range saturates to the deepest curve
        write_order(4'd15);
        queue_words(1'b1, 4);
        // order written mid-curve only counts from the next start
        write_order(4'd2);
        queue_words(1'b0, 2);
        queue_words(1'b1, 2);
        write_order(4'd8);
        queue_words(1'b1, 4);
        queue_words(1'b1, 1);

        random_words = 0;
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            if (phase == 0) begin
                ord = 4'd3;
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: ord = 4'($urandom_range(3, 1));
                    6, 7:             ord = 4'($urandom_range(8, 4));
                    default:          ord = 4'($urandom_range(15, 0));
                endcase
            end
            write_order(ord);
            idle_mode = t_idle_mode'(phase % 4);
            eff = (ord > hcsg_pkg::MAX_ORDER) ? hcsg_pkg::MAX_ORDER : ord;
            if (phase == 0) begin
                pressure_go = 1'b1;
                queue_words(1'b1, 63 + 2);
                random_words += 66;
            end else if ($urandom_range(9) == 0) begin
                // noise: mostly advances with stray starts
                adv = $urandom_range(30, 10);
                for (int i = 0; i < adv; i++)
                    start_bits_q.push_back($urandom_range(7) == 0);
                random_words += adv;
            end else begin
                if (eff == 0)
                    adv = $urandom_range(3, 1);
                else if (eff <= 3 && $urandom_range(3) != 0)
                    adv = (1 << (2 * eff)) - 1 + $urandom_range(2, 0);
                else if (eff <= 3)
                    adv = $urandom_range((1 << (2 * eff)) - 2, 0);
                else
                    adv = $urandom_range(80, 10);
                queue_words(1'b1, adv);
                random_words += adv + 1;
                // sometimes restart before the curve is through
                if ($urandom_range(4) == 0) begin
                    adv = $urandom_range(6, 0);
                    queue_words(1'b1, adv);
                    random_words += adv + 1;
                end
            end
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        errors += pending_segs.size();
        $display("covered %0d words (%0d starts), %0d results, %0d curves finished, %0d done",
                 n_words, n_starts, n_results, n_last, n_done);
        $display("orders written (bit mask) %h over %0d random phases, %0d mismatches",
                 orders_written, phase, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
